// ----- rtl/core/xbe_pkg.sv -----
// xbe_pkg: character constants, run type and escape function for the xml byte escaper
// no dependencies
`default_nettype none

package xbe_pkg;

  localparam int unsigned RunMax = 6;

  typedef logic [2:0] run_len_t;
  typedef logic [2:0] run_idx_t;

  typedef struct packed {
    logic [RunMax-1:0][7:0] bytes;
    run_len_t               len;
  } run_t;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_QUOT  = 8'h22;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_RBRK  = 8'h5d;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_M     = 8'h6d;
  localparam logic [7:0] CH_O     = 8'h6f;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_Q     = 8'h71;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  function automatic logic passes_through(input logic [7:0] c);
    logic pass;
    pass = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h61 && c <= 8'h7a) ||
           c == CH_SPACE || c == CH_DASH || c == CH_TAB || c == CH_NL ||
           c == CH_COMMA || c == CH_DOT || c == CH_SEMI || c == CH_COLON ||
           c == CH_LPAR || c == CH_RPAR || c == CH_LBRK || c == CH_RBRK ||
           c == CH_HASH || c == CH_SLASH;
    return pass;
  endfunction

  // decimal digits by compare-subtract for hundreds, reciprocal multiply for tens
  function automatic run_t escape_byte(input logic [7:0] c);
    run_t        r;
    logic [1:0]  h;
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [3:0]  ones;
    r.bytes = '0;
    r.len   = run_len_t'(1);
    if (c >= 8'd200) begin
      h   = 2'd2;
      rem = 7'(c - 8'd200);
    end else if (c >= 8'd100) begin
      h   = 2'd1;
      rem = 7'(c - 8'd100);
    end else begin
      h   = 2'd0;
      rem = 7'(c);
    end
    prod = 15'(rem) * 15'd205;
    tens = 4'(prod >> 11);
    ones = 4'(rem - 7'({3'b000, tens} * 7'd10));
    if (passes_through(c)) begin
      r.bytes[0] = c;
    end else if (c == CH_AMP) begin
      r.bytes[0] = CH_AMP; r.bytes[1] = CH_A; r.bytes[2] = CH_M;
      r.bytes[3] = CH_P;   r.bytes[4] = CH_SEMI;
      r.len = run_len_t'(5);
    end else if (c == CH_APOS) begin
      r.bytes[0] = CH_AMP; r.bytes[1] = CH_A; r.bytes[2] = CH_P;
      r.bytes[3] = CH_O;   r.bytes[4] = CH_S; r.bytes[5] = CH_SEMI;
      r.len = run_len_t'(6);
    end else if (c == CH_QUOT) begin
      r.bytes[0] = CH_AMP; r.bytes[1] = CH_Q; r.bytes[2] = CH_U;
      r.bytes[3] = CH_O;   r.bytes[4] = CH_T; r.bytes[5] = CH_SEMI;
      r.len = run_len_t'(6);
    end else if (c == CH_LT) begin
      r.bytes[0] = CH_AMP; r.bytes[1] = CH_L; r.bytes[2] = CH_T;
      r.bytes[3] = CH_SEMI;
      r.len = run_len_t'(4);
    end else if (c == CH_GT) begin
      r.bytes[0] = CH_AMP; r.bytes[1] = CH_G; r.bytes[2] = CH_T;
      r.bytes[3] = CH_SEMI;
      r.len = run_len_t'(4);
    end else if (c >= 8'd100) begin
      r.bytes[0] = CH_AMP;        r.bytes[1] = CH_HASH;
      r.bytes[2] = {6'h0c, h};    r.bytes[3] = {4'h3, tens};
      r.bytes[4] = {4'h3, ones};  r.bytes[5] = CH_SEMI;
      r.len = run_len_t'(6);
    end else if (c >= 8'd10) begin
      r.bytes[0] = CH_AMP;        r.bytes[1] = CH_HASH;
      r.bytes[2] = {4'h3, tens};  r.bytes[3] = {4'h3, ones};
      r.bytes[4] = CH_SEMI;
      r.len = run_len_t'(5);
    end else begin
      r.bytes[0] = CH_AMP;        r.bytes[1] = CH_HASH;
      r.bytes[2] = {4'h3, ones};  r.bytes[3] = CH_SEMI;
      r.len = run_len_t'(4);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/xml_byte_escaper.sv -----
// xml_byte_escaper: top level, escapes one raw byte per request into a run of output bytes
// depends on xbe_pkg
`default_nettype none

// Each input request carries one raw byte and a buffer-end flag. It is held in an
// input register, escaped by short combinational logic (pass-through, one of the five
// named entities, or a decimal character reference) and loaded into a run register of
// up to six bytes, which is then sent one byte per cycle while out_ready is high.
// run_last marks the final byte of each run and buffer_done copies buffer_end onto
// that byte. A run holds one byte for a pass-through character and four to six bytes
// for an escaped one. The input register takes the next request while the current run
// is still being sent, so with a ready consumer the output never stalls between runs.
// Reset clears the valid flags and the output byte pointer.

module xml_byte_escaper
  import xbe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       buffer_end,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            run_last,
  output logic            buffer_done
);

  // input register
  logic       a_valid;
  logic [7:0] a_byte;
  logic       a_end;

  // run register with output pointer
  logic     b_valid;
  run_t     b_run;
  logic     b_end;
  run_idx_t b_idx;

  run_t a_run;
  logic out_fire;
  logic b_finish;
  logic a_move;

  // escape the held byte
  assign a_run = escape_byte(a_byte);

  assign out_valid   = b_valid;
  assign out_byte    = b_run.bytes[b_idx];
  assign run_last    = (b_idx == run_idx_t'(b_run.len - run_len_t'(1)));
  assign buffer_done = run_last & b_end;

  assign out_fire = out_valid & out_ready;
  assign b_finish = out_fire & run_last;
  // run register frees up when empty or on its last byte going out
  assign a_move   = a_valid & (~b_valid | b_finish);
  assign in_ready = ~a_valid | a_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      b_idx   <= '0;
    end else begin
      if (in_valid && in_ready) begin
        a_valid <= 1'b1;
        a_byte  <= in_byte;
        a_end   <= buffer_end;
      end else if (a_move) begin
        a_valid <= 1'b0;
      end

      if (a_move) begin
        b_valid <= 1'b1;
        b_run   <= a_run;
        b_end   <= a_end;
        b_idx   <= '0;
      end else if (b_finish) begin
        b_valid <= 1'b0;
        b_idx   <= '0;
      end else if (out_fire) begin
        b_idx <= b_idx + run_idx_t'(1);
      end
    end
  end

endmodule

`default_nettype wire
